// File: hdl/dhs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhs_pkg
// shared types and constants of the double hashing set
// ----------------------------------------------------------------------------
package dhs_pkg;

  localparam int SLOTS_DEF    = 256;
  localparam int KEY_BITS_DEF = 16;

  localparam int KIND_W   = 2;
  localparam int KEY_W    = 16;
  localparam int PRIME_W  = 16;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 8;
  localparam int TAG_W    = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [PRIME_W-1:0] PRIME_ONE_RST = 16'd31;
  localparam logic [PRIME_W-1:0] PRIME_TWO_RST = 16'd37;

  localparam logic [CFG_IDX_W-1:0] CFG_PRIME_ONE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIME_TWO = 1'b1;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TEST   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  localparam logic [TAG_W-1:0] TAG_EMPTY = 2'd0;
  localparam logic [TAG_W-1:0] TAG_USED  = 2'd1;
  localparam logic [TAG_W-1:0] TAG_TOMB  = 2'd2;

  // x / 10 == (x * 52429) >> 19 for any 16-bit x
  localparam int DIV10_MUL   = 52429;
  localparam int DIV10_SHIFT = 19;

  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_POS,
    SEL_TOMB
  } res_sel_t;

  typedef struct packed {
    logic                clear;
    logic                load;
    logic                hash_step;
    logic                probe_init;
    logic                probe_adv;
    logic                wr_en;
    logic [TAG_W-1:0]    wr_tag;
    logic                wr_at_tomb;
    logic                fill_inc;
    logic                res_load;
    logic [STATUS_W-1:0] res_status;
    res_sel_t            res_sel;
    logic                out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic              sweep_last;
    logic [KIND_W-1:0] kind;
    logic              full;
    logic              rem_zero;
    logic              hit;
    logic              is_empty;
    logic              is_tomb;
    logic              tomb_any;
    logic              probe_last;
  } dp_stat_t;

endpackage

// File: hdl/dhs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhs_if
// request, result and configuration channels
// ----------------------------------------------------------------------------
interface dhs_req_if import dhs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [KEY_W-1:0]  key;
  modport source(output valid, kind, key, input ready);
  modport sink(input valid, kind, key, output ready);
endinterface

interface dhs_res_if import dhs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  modport source(output valid, status, slot, input ready);
  modport sink(input valid, status, slot, output ready);
endinterface

interface dhs_cfg_if import dhs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [PRIME_W-1:0]   data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: hdl/dhs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhs_ram
// generic single write, single read ram with registered read
// ----------------------------------------------------------------------------
module dhs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/dhs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhs_datapath
// digit hashing, probe address walk, slot ram, fill count and result words
// ----------------------------------------------------------------------------
module dhs_datapath import dhs_pkg::*; #(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PRIME_W-1:0]   cfg_data,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [KEY_W-1:0]     in_key,
  output logic [STATUS_W-1:0]  out_status,
  output logic [SLOT_W-1:0]    out_slot
);
  localparam int SB   = $clog2(SLOTS);
  localparam int KW   = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int RW   = KW + TAG_W;
  localparam int PW   = KW + 17;
  localparam int FULL_LIM = 3 * SLOTS;

  logic [PRIME_W-1:0]  prime_one, prime_two;
  logic [KIND_W-1:0]   kind;
  logic [KW-1:0]       key;
  logic [KW-1:0]       rem;
  logic [SB-1:0]       h1, h2;
  logic [SB-1:0]       pos, stp, tomb, cnt, sweep;
  logic                have_tomb;
  logic [SB:0]         fill;
  logic [STATUS_W-1:0] res_status;
  logic [SLOT_W-1:0]   res_slot;

  logic [PW-1:0]       prod;
  logic [KW-1:0]       quot;
  logic [KW+3:0]       quot10;
  logic [3:0]          digit;
  logic [SB+15:0]      m1, m2;
  logic [RW-1:0]       rdata, wdata;
  logic [SB-1:0]       waddr;
  logic [TAG_W-1:0]    rtag;
  logic [SB-1:0]       tomb_pos;

  // one decimal digit per step
  assign prod   = PW'(rem) * PW'(DIV10_MUL);
  assign quot   = KW'(prod >> DIV10_SHIFT);
  assign quot10 = (KW+4)'(quot) * (KW+4)'(10);
  assign digit  = 4'(rem - quot10[KW-1:0]);
  assign m1     = (SB+16)'(h1) * (SB+16)'(prime_one);
  assign m2     = (SB+16)'(h2) * (SB+16)'(prime_two);

  assign rtag     = rdata[RW-1:KW];
  assign tomb_pos = have_tomb ? tomb : pos;

  assign stat.sweep_last = &sweep;
  assign stat.kind       = kind;
  assign stat.full       = {fill, 2'b00} >= (SB+3)'(FULL_LIM);
  assign stat.rem_zero   = (rem == '0);
  assign stat.hit        = (rtag == TAG_USED) && (rdata[KW-1:0] == key);
  assign stat.is_empty   = (rtag == TAG_EMPTY);
  assign stat.is_tomb    = (rtag == TAG_TOMB);
  assign stat.tomb_any   = have_tomb || (rtag == TAG_TOMB);
  assign stat.probe_last = &cnt;

  assign waddr = cmd.clear ? sweep : (cmd.wr_at_tomb ? tomb_pos : pos);
  assign wdata = cmd.clear ? '0 : {cmd.wr_tag, key};

  dhs_ram #(.WIDTH(RW), .DEPTH(SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (cmd.clear || cmd.wr_en),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (pos),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      prime_one <= PRIME_ONE_RST;
      prime_two <= PRIME_TWO_RST;
      fill      <= '0;
      sweep     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PRIME_ONE: prime_one <= cfg_data;
          CFG_PRIME_TWO: prime_two <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.clear) begin
        sweep <= sweep + 1'b1;
      end
      if (cmd.fill_inc) begin
        fill <= fill + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind <= in_kind;
      key  <= KW'(in_key);
      rem  <= KW'(in_key);
      h1   <= '0;
      h2   <= '0;
    end else if (cmd.hash_step && (rem != '0)) begin
      rem <= quot;
      h1  <= m1[SB-1:0] + SB'(digit);
      h2  <= m2[SB-1:0] + SB'(digit);
    end
    if (cmd.probe_init) begin
      pos       <= h1;
      stp       <= {h2[SB-2:0], 1'b1};
      cnt       <= '0;
      have_tomb <= 1'b0;
    end else if (cmd.probe_adv) begin
      pos <= pos + stp;
      cnt <= cnt + 1'b1;
      if ((rtag == TAG_TOMB) && !have_tomb) begin
        have_tomb <= 1'b1;
        tomb      <= pos;
      end
    end
    if (cmd.res_load) begin
      res_status <= cmd.res_status;
      case (cmd.res_sel)
        SEL_POS:  res_slot <= SLOT_W'(pos);
        SEL_TOMB: res_slot <= SLOT_W'(tomb_pos);
        default:  res_slot <= '0;
      endcase
    end
    if (cmd.out_load) begin
      out_status <= res_status;
      out_slot   <= res_slot;
    end
  end
endmodule

// File: hdl/dhs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhs_ctrl
// sequencer for table clear, hashing, probing and result hand-off
// ----------------------------------------------------------------------------
module dhs_ctrl import dhs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_RD,
    S_CHK,
    S_FIN
  } state_t;

  state_t state;
  logic   early, stop, out_free, is_ins;

  assign is_ins   = (stat.kind == KIND_INSERT);
  assign early    = (stat.kind == KIND_NONE) || (is_ins && stat.full);
  assign stop     = stat.hit || stat.is_empty || stat.probe_last;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd = '0;
    cmd.res_sel = SEL_ZERO;
    case (state)
      S_CLEAR: cmd.clear = 1'b1;
      S_IDLE:  cmd.load = in_valid;
      S_HASH: begin
        if (early) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = (stat.kind == KIND_NONE) ? ST_MISS : ST_FULL;
        end else begin
          cmd.hash_step  = 1'b1;
          cmd.probe_init = stat.rem_zero;
        end
      end
      S_CHK: begin
        cmd.probe_adv = !stop;
        if (stat.hit) begin
          cmd.res_load   = 1'b1;
          cmd.res_sel    = SEL_POS;
          cmd.res_status = is_ins ? ST_MISS : ST_DONE;
          cmd.wr_en      = (stat.kind == KIND_DELETE);
          cmd.wr_tag     = TAG_TOMB;
        end else if (stop) begin
          cmd.res_load = 1'b1;
          if (!is_ins) begin
            cmd.res_status = ST_MISS;
          end else if (stat.tomb_any) begin
            cmd.res_status = ST_DONE;
            cmd.res_sel    = SEL_TOMB;
            cmd.wr_en      = 1'b1;
            cmd.wr_tag     = TAG_USED;
            cmd.wr_at_tomb = 1'b1;
          end else if (stat.is_empty) begin
            cmd.res_status = ST_DONE;
            cmd.res_sel    = SEL_POS;
            cmd.wr_en      = 1'b1;
            cmd.wr_tag     = TAG_USED;
            cmd.fill_inc   = 1'b1;
          end else begin
            cmd.res_status = ST_FULL;
          end
        end
      end
      S_FIN: cmd.out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      in_ready  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (stat.sweep_last) begin
            state    <= S_IDLE;
            in_ready <= 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            state    <= S_HASH;
            in_ready <= 1'b0;
          end
        end
        S_HASH: begin
          if (early) begin
            state <= S_FIN;
          end else if (stat.rem_zero) begin
            state <= S_RD;
          end
        end
        S_RD: state <= S_CHK;
        S_CHK: state <= stop ? S_FIN : S_RD;
        S_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            in_ready  <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end
endmodule

// File: hdl/double_hash_set_unit.sv
`timescale 1ns / 1ps
// a request is hashed one decimal digit of the key at a time, then each probed slot is read
// and checked; kind three or an insert at three-quarter fill answers without hashing or probing
// throughput: one request at a time, the next is taken once in_ready returns with the result word
// the digit hash loop (two prime multiplies per digit) and the slot ram read per probe set the rate
// reset: synchronous, active high; afterwards a clearing pass empties every slot
// before the first request is taken; config is accepted throughout
// ----------------------------------------------------------------------------
// double_hash_set_unit
// open addressing hash set with double hashing and tombstones
// ----------------------------------------------------------------------------
module double_hash_set_unit import dhs_pkg::*; #(
  parameter int SLOTS    = SLOTS_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  dhs_req_if.sink  in_ch,
  dhs_res_if.source out_ch,
  dhs_cfg_if.sink  cfg_ch
);
  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  dhs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dhs_datapath #(.SLOTS(SLOTS), .KEY_BITS(KEY_BITS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg_ch.valid),
    .cfg_index  (cfg_ch.index),
    .cfg_data   (cfg_ch.data),
    .in_kind    (in_ch.kind),
    .in_key     (in_ch.key),
    .out_status (out_ch.status),
    .out_slot   (out_ch.slot)
  );
endmodule

// File: hdl/dhs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhs_checker
// port level checks of the double hashing set
// ----------------------------------------------------------------------------
module dhs_checker import dhs_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic [SLOT_W-1:0]   out_slot
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_slot))
    else $error("result word changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in flight");

  a_full_no_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status == ST_FULL) |-> out_slot == '0)
    else $error("full result carries a slot");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_status <= ST_FULL)
    else $error("undefined result status");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid && !in_ready)
    else $error("handshake active right after reset");
endmodule

bind double_hash_set_unit dhs_checker u_dhs_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_slot   (out_ch.slot)
);
